### src/bmdc_pkg.sv
// ----------------------------------------------------------------------------
// bmdc_pkg
// Shared types and constants for the BGP message deframer and counter.
// ----------------------------------------------------------------------------
package bmdc_pkg;

	// Parser phase, in stream order; payload phases start at PH_BODY
	typedef enum logic [3:0] {
		PH_MARKER = 4'd0,
		PH_LEN_HI = 4'd1,
		PH_LEN_LO = 4'd2,
		PH_TYPE   = 4'd3,
		PH_BODY   = 4'd4,
		PH_WL_HI  = 4'd5,
		PH_WL_LO  = 4'd6,
		PH_WD     = 4'd7,
		PH_PA_HI  = 4'd8,
		PH_PA_LO  = 4'd9,
		PH_PA     = 4'd10,
		PH_NLRI   = 4'd11,
		PH_SKIP   = 4'd12
	} phase_t;

	// Status codes
	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_BAD_MARKER   = 3'd1;
	localparam logic [2:0] ST_SHORT_LEN    = 3'd2;
	localparam logic [2:0] ST_WD_OVERRUN   = 3'd3;
	localparam logic [2:0] ST_ATTR_OVERRUN = 3'd4;
	localparam logic [2:0] ST_PFX_LONG     = 3'd5;
	localparam logic [2:0] ST_PFX_OVERRUN  = 3'd6;
	localparam logic [2:0] ST_TRUNC        = 3'd7;

	// Message type codes
	localparam logic [7:0] TYPE_OPEN      = 8'd1;
	localparam logic [7:0] TYPE_UPDATE    = 8'd2;
	localparam logic [7:0] TYPE_NOTIFY    = 8'd3;
	localparam logic [7:0] TYPE_KEEPALIVE = 8'd4;

	// Framing constants
	localparam logic [7:0]  MARKER_BYTE = 8'hFF;
	localparam logic [15:0] MARKER_LAST = 16'd15;   // index of the 16th marker byte
	localparam logic [15:0] HDR_LEN     = 16'd19;
	localparam logic [7:0]  PREFIX_MAX  = 8'd32;
	localparam logic [15:0] EOR_LEN     = 16'd4;

	// Payload positions of the OPEN peer AS and NOTIFICATION code bytes
	localparam logic [15:0] POS_AS_HI   = 16'd2;
	localparam logic [15:0] POS_AS_LO   = 16'd3;
	localparam logic [15:0] POS_CODE    = 16'd1;
	localparam logic [15:0] POS_SUBCODE = 16'd2;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 112;

	// One result beat; msg_type sits in the lowest bits
	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  notify_subcode;
		logic [7:0]  notify_code;
		logic [15:0] peer_as;
		logic        is_eor;
		logic [15:0] path_attr_len;
		logic [15:0] nlri_pfx_cnt;
		logic [15:0] wd_pfx_cnt;
		logic [15:0] payload_len;
		logic [7:0]  msg_type;
	} bmdc_result_t;

	localparam int RESULT_W = $bits(bmdc_result_t);

	// Parser state
	typedef struct packed {
		phase_t      phase;
		logic [15:0] pos;       // marker bytes seen, then payload bytes seen
		logic [15:0] left;      // payload bytes still to come
		logic [7:0]  typ;
		logic [15:0] wleft;     // withdrawn bytes left, then attribute bytes left
		logic [15:0] attr;
		logic [2:0]  pskip;     // prefix address bytes still to skip
		logic [15:0] wtally;
		logic [15:0] ntally;
		logic [15:0] peer_as;
		logic [15:0] code;      // code high byte, subcode low byte
		logic [2:0]  ferr;
	} bmdc_state_t;

	localparam bmdc_state_t STATE_CLEAR = '{
		phase:   PH_MARKER,
		pos:     16'd0,
		left:    16'd0,
		typ:     8'd0,
		wleft:   16'd0,
		attr:    16'd0,
		pskip:   3'd0,
		wtally:  16'd0,
		ntally:  16'd0,
		peer_as: 16'd0,
		code:    16'd0,
		ferr:    ST_OK
	};

endpackage

### src/bgp_message_deframer_counter.sv
// ----------------------------------------------------------------------------
// bgp_message_deframer_counter
// BGP byte-stream deframer: marker check, header decode and per-message
// prefix, AS and notification summary.
// ----------------------------------------------------------------------------
// Takes one stream byte per beat and sustains one beat per clock while the
// sink takes results. Each beat passes an input register, then the framing
// state machine, whose result lands in an output register, so m_axis_tvalid
// rises once the beat that ends its message has passed through both (the
// last payload byte, a bad marker byte, a short length, or a stream-end beat
// inside a message). While a result waits in the output register and the
// sink holds tready low, the state machine holds every beat, with or without
// a result, so input stops once the input register is full and resumes the
// cycle the sink takes the result. tuser set on an input beat marks stream
// end and its byte is ignored.
module bgp_message_deframer_counter import bmdc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic                   s_axis_tuser,   // [0] stream_end
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// [7:0] msg_type, [23:8] payload_len, [39:24] wd_pfx_cnt,
	// [55:40] nlri_pfx_cnt, [71:56] path_attr_len, [72] is_eor,
	// [88:73] peer_as, [96:89] notify_code, [104:97] notify_subcode,
	// [107:105] status, [111:108] zero
	output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         end_s1;
	logic         free;
	logic         step;
	logic         res_valid;
	bmdc_result_t res;

	// Parser advances whenever a beat is held and the result slot can take output
	assign step = valid_s1 && free;

	bmdc_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_end   (s_axis_tuser),
		.take     (step),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.end_s1   (end_s1)
	);

	bmdc_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.in_byte   (byte_s1),
		.in_end    (end_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	bmdc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (res_valid),
		.res       (res),
		.free      (free),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

### src/bmdc_in_reg.sv
// ----------------------------------------------------------------------------
// bmdc_in_reg
// Input register stage: holds one received beat until the parser takes it.
// ----------------------------------------------------------------------------
module bmdc_in_reg import bmdc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_end,
	input  logic       take,        // parser consumes the held beat
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       end_s1
);

	logic load;

	// Refill in the same cycle the held beat leaves
	assign in_ready = !valid_s1 || take;
	assign load     = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= in_byte;
			end_s1  <= in_end;
		end
	end

endmodule

### src/bmdc_parser.sv
// ----------------------------------------------------------------------------
// bmdc_parser
// Per-byte framing state machine; walks header and payload, counts prefixes
// and builds the result of each message.
// ----------------------------------------------------------------------------
module bmdc_parser import bmdc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         step,        // one beat applied this cycle
	input  logic [7:0]   in_byte,
	input  logic         in_end,
	output logic         res_valid,
	output bmdc_result_t res
);

	typedef struct packed {
		logic [2:0]  skip;
		logic [15:0] tally;
		logic [2:0]  err;
	} pfx_t;

	bmdc_state_t cur;
	bmdc_state_t upd;
	bmdc_state_t nxt;
	logic        emit;
	logic        bare;
	logic        fin;
	logic        do_clear;
	logic [2:0]  st;
	logic [2:0]  err;
	logic [15:0] len_full;
	pfx_t        pfx;

	// One byte of a prefix section: length byte or skipped address byte
	function automatic pfx_t prefix_step(input logic [2:0] skip, input logic [7:0] b,
			input logic [15:0] room, input logic [15:0] tally);
		pfx_t       r;
		logic [2:0] need;
		r.skip  = skip;
		r.tally = tally;
		r.err   = ST_OK;
		need    = 3'(b[5:3] + {2'b00, |b[2:0]});
		if (skip != 3'd0) begin
			r.skip = skip - 3'd1;
		end else begin
			r.tally = tally + 16'd1;
			if (b > PREFIX_MAX) begin
				r.err = ST_PFX_LONG;
			end else if ({13'd0, need} > room) begin
				r.err = ST_PFX_OVERRUN;
			end else begin
				r.skip = need;
			end
		end
		return r;
	endfunction

	// Result fields from the gathered state
	function automatic bmdc_result_t fill(input bmdc_state_t s, input logic [2:0] code_st);
		bmdc_result_t r;
		logic         is_upd;
		logic [15:0]  plen;
		is_upd = (s.typ == TYPE_UPDATE);
		plen   = (s.phase >= PH_BODY) ? 16'(s.pos + s.left) : 16'd0;
		r.msg_type        = s.typ;
		r.payload_len     = plen;
		r.wd_pfx_cnt      = is_upd ? s.wtally : 16'd0;
		r.nlri_pfx_cnt    = is_upd ? s.ntally : 16'd0;
		r.path_attr_len   = is_upd ? s.attr : 16'd0;
		r.is_eor          = is_upd && (plen == EOR_LEN);
		r.peer_as         = (s.typ == TYPE_OPEN) ? s.peer_as : 16'd0;
		r.notify_code     = (s.typ == TYPE_NOTIFY) ? s.code[15:8] : 8'd0;
		r.notify_subcode  = (s.typ == TYPE_NOTIFY) ? s.code[7:0] : 8'd0;
		r.status          = code_st;
		return r;
	endfunction

	assign len_full = {cur.left[15:8], in_byte};

	// Next state
	always_comb begin
		upd      = cur;
		emit     = 1'b0;
		bare     = 1'b0;
		fin      = 1'b0;
		do_clear = 1'b0;
		st       = ST_OK;
		err      = ST_OK;
		pfx      = '0;
		if (in_end) begin
			// stream closed: report a partial message, if any
			do_clear = 1'b1;
			if (!(cur.phase == PH_MARKER && cur.pos == 16'd0)) begin
				emit = 1'b1;
				st   = (cur.ferr != ST_OK) ? cur.ferr : ST_TRUNC;
			end
		end else begin
			unique case (cur.phase)
				PH_MARKER: begin
					if (in_byte != MARKER_BYTE) begin
						do_clear = 1'b1;
						emit     = 1'b1;
						bare     = 1'b1;
						st       = ST_BAD_MARKER;
					end else if (cur.pos == MARKER_LAST) begin
						upd.pos   = 16'd0;
						upd.phase = PH_LEN_HI;
					end else begin
						upd.pos = cur.pos + 16'd1;
					end
				end
				PH_LEN_HI: begin
					upd.left  = {in_byte, 8'd0};
					upd.phase = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					if (len_full < HDR_LEN) begin
						do_clear = 1'b1;
						emit     = 1'b1;
						bare     = 1'b1;
						st       = ST_SHORT_LEN;
					end else begin
						upd.left  = len_full - HDR_LEN;
						upd.phase = PH_TYPE;
					end
				end
				PH_TYPE: begin
					upd.typ   = in_byte;
					upd.pos   = 16'd0;
					upd.phase = (in_byte == TYPE_UPDATE) ? PH_WL_HI : PH_BODY;
					fin       = (cur.left == 16'd0);
				end
				default: begin
					if (cur.left == 16'd0) begin
						do_clear = 1'b1;
					end else begin
						upd.left = cur.left - 16'd1;
						upd.pos  = cur.pos + 16'd1;
						unique case (cur.phase)
							PH_BODY: begin
								if (cur.typ == TYPE_OPEN) begin
									if (upd.pos == POS_AS_HI) upd.peer_as[15:8] = in_byte;
									else if (upd.pos == POS_AS_LO) upd.peer_as[7:0] = in_byte;
								end else if (cur.typ == TYPE_NOTIFY) begin
									if (upd.pos == POS_CODE) upd.code[15:8] = in_byte;
									else if (upd.pos == POS_SUBCODE) upd.code[7:0] = in_byte;
								end
							end
							PH_WL_HI: begin
								upd.wleft = {in_byte, 8'd0};
								upd.phase = PH_WL_LO;
							end
							PH_WL_LO: begin
								upd.wleft = {cur.wleft[15:8], in_byte};
								if (upd.wleft > upd.left) err = ST_WD_OVERRUN;
								else upd.phase = (upd.wleft == 16'd0) ? PH_PA_HI : PH_WD;
							end
							PH_WD: begin
								upd.wleft  = cur.wleft - 16'd1;
								pfx        = prefix_step(cur.pskip, in_byte, upd.wleft, cur.wtally);
								upd.pskip  = pfx.skip;
								upd.wtally = pfx.tally;
								err        = pfx.err;
								if (pfx.err == ST_OK && upd.wleft == 16'd0) upd.phase = PH_PA_HI;
							end
							PH_PA_HI: begin
								upd.attr  = {in_byte, 8'd0};
								upd.phase = PH_PA_LO;
							end
							PH_PA_LO: begin
								upd.attr  = {cur.attr[15:8], in_byte};
								upd.wleft = upd.attr;
								if (upd.attr > upd.left) err = ST_ATTR_OVERRUN;
								else upd.phase = (upd.attr == 16'd0) ? PH_NLRI : PH_PA;
							end
							PH_PA: begin
								upd.wleft = cur.wleft - 16'd1;
								if (upd.wleft == 16'd0) upd.phase = PH_NLRI;
							end
							PH_NLRI: begin
								pfx        = prefix_step(cur.pskip, in_byte, upd.left, cur.ntally);
								upd.pskip  = pfx.skip;
								upd.ntally = pfx.tally;
								err        = pfx.err;
							end
							default: begin
							end
						endcase
						// first error wins; skip the rest of the message
						if (err != ST_OK) begin
							if (cur.ferr == ST_OK) upd.ferr = err;
							upd.phase = PH_SKIP;
						end
						fin = (upd.left == 16'd0);
					end
				end
			endcase
			// last payload byte: report and restart
			if (fin) begin
				emit     = 1'b1;
				do_clear = 1'b1;
				if (upd.ferr != ST_OK) st = upd.ferr;
				else if (upd.phase == PH_WL_HI || upd.phase == PH_WL_LO) st = ST_WD_OVERRUN;
				else if (upd.phase == PH_PA_HI || upd.phase == PH_PA_LO) st = ST_ATTR_OVERRUN;
				else st = ST_OK;
			end
		end
		nxt = do_clear ? STATE_CLEAR : upd;
	end

	// Result
	always_comb begin
		res_valid = step && emit;
		if (bare) begin
			res        = '0;
			res.status = st;
		end else begin
			res = fill(upd, st);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur <= STATE_CLEAR;
		end else if (step) begin
			cur <= nxt;
		end
	end

endmodule

### src/bmdc_out_reg.sv
// ----------------------------------------------------------------------------
// bmdc_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module bmdc_out_reg import bmdc_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  bmdc_result_t           res,
	output logic                   free,      // room for a new result this cycle
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [OUT_TDATA_W-1:0] out_data
);

	bmdc_result_t res_q;

	assign free     = !out_valid || out_ready;
	assign out_data = {{(OUT_TDATA_W - RESULT_W){1'b0}}, res_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

### sim/tb_bgp_message_deframer_counter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bgp_message_deframer_counter
// Self-checking bench for the BGP byte-stream deframer and counter.
// ----------------------------------------------------------------------------
// Feeds framed BGP messages one byte per beat: keepalives, OPENs,
// NOTIFICATIONs and UPDATEs with counted prefixes. Broken frames are mixed in:
// bad markers, short lengths, oversized section lengths, long or overrunning
// prefixes, and streams closed mid-message. A behavioral parser inside the
// scoreboard predicts one summary per message. Each result beat is compared
// field by field with the oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------

import bmdc_pkg::*;

class msg_summary_board;
	// parser state, mirrors what the block must hold
	phase_t      ph;
	logic [15:0] pos, left, wleft, attr, wtally, ntally, asn, code;
	logic [7:0]  typ;
	logic [2:0]  pskip, ferr;

	bmdc_result_t summary_q[$];
	int errors;
	int checked;
	int produced;
	int st_seen[8];

	function new();
		clear();
	endfunction

	function void clear();
		ph     = PH_MARKER;
		pos    = '0;
		left   = '0;
		wleft  = '0;
		attr   = '0;
		wtally = '0;
		ntally = '0;
		asn    = '0;
		code   = '0;
		typ    = '0;
		pskip  = '0;
		ferr   = ST_OK;
	endfunction

	function int pending();
		return summary_q.size();
	endfunction

	// queue the summary of the message gathered so far
	function void emit(logic [2:0] st);
		bmdc_result_t r;
		logic [15:0]  plen;
		r    = '0;
		plen = (ph >= PH_BODY) ? 16'(pos + left) : 16'd0;
		r.msg_type    = typ;
		r.payload_len = plen;
		if (typ == TYPE_UPDATE) begin
			r.wd_pfx_cnt    = wtally;
			r.nlri_pfx_cnt  = ntally;
			r.path_attr_len = attr;
			r.is_eor        = (plen == EOR_LEN);
		end
		if (typ == TYPE_OPEN)
			r.peer_as = asn;
		if (typ == TYPE_NOTIFY) begin
			r.notify_code    = code[15:8];
			r.notify_subcode = code[7:0];
		end
		r.status = st;
		summary_q.push_back(r);
		produced++;
	endfunction

	// last payload byte seen: summarize, then back to marker search
	function void finish_msg();
		logic [2:0] st;
		st = ferr;
		if (st == ST_OK) begin
			if (ph == PH_WL_HI || ph == PH_WL_LO)
				st = ST_WD_OVERRUN;
			else if (ph == PH_PA_HI || ph == PH_PA_LO)
				st = ST_ATTR_OVERRUN;
		end
		emit(st);
		clear();
	endfunction

	// one byte of a prefix list; room is what is left of the section
	function logic [2:0] prefix_step(logic [7:0] b, logic [15:0] room, bit in_nlri);
		int need;
		if (pskip != 0) begin
			pskip--;
			return ST_OK;
		end
		if (in_nlri)
			ntally++;
		else
			wtally++;
		if (b > PREFIX_MAX)
			return ST_PFX_LONG;
		need = (int'(b) + 7) >> 3;
		if (need > int'(room))
			return ST_PFX_OVERRUN;
		pskip = 3'(need);
		return ST_OK;
	endfunction

	function logic [2:0] body_step(logic [7:0] b);
		logic [2:0] err;
		err = ST_OK;
		case (ph)
			PH_BODY: begin
				if (typ == TYPE_OPEN) begin
					if (pos == POS_AS_HI)
						asn[15:8] = b;
					else if (pos == POS_AS_LO)
						asn[7:0] = b;
				end else if (typ == TYPE_NOTIFY) begin
					if (pos == POS_CODE)
						code[15:8] = b;
					else if (pos == POS_SUBCODE)
						code[7:0] = b;
				end
			end
			PH_WL_HI: begin
				wleft = {b, 8'h00};
				ph    = PH_WL_LO;
			end
			PH_WL_LO: begin
				wleft[7:0] = b;
				if (wleft > left)
					err = ST_WD_OVERRUN;
				else
					ph = (wleft == 0) ? PH_PA_HI : PH_WD;
			end
			PH_WD: begin
				wleft--;
				err = prefix_step(b, wleft, 1'b0);
				if (err == ST_OK && wleft == 0)
					ph = PH_PA_HI;
			end
			PH_PA_HI: begin
				attr = {b, 8'h00};
				ph   = PH_PA_LO;
			end
			PH_PA_LO: begin
				attr[7:0] = b;
				wleft     = attr;
				if (attr > left)
					err = ST_ATTR_OVERRUN;
				else
					ph = (attr == 0) ? PH_NLRI : PH_PA;
			end
			PH_PA: begin
				wleft--;
				if (wleft == 0)
					ph = PH_NLRI;
			end
			PH_NLRI: begin
				err = prefix_step(b, left, 1'b1);
			end
			default: ;
		endcase
		return err;
	endfunction

	// advance the parser by one accepted input beat
	function void note_beat(logic [7:0] b, logic stream_end);
		logic [2:0] err;
		if (stream_end) begin
			if (!(ph == PH_MARKER && pos == 0))
				emit((ferr != ST_OK) ? ferr : ST_TRUNC);
			clear();
			return;
		end
		case (ph)
			PH_MARKER: begin
				if (b != MARKER_BYTE) begin
					clear();
					emit(ST_BAD_MARKER);
				end else if (pos == MARKER_LAST) begin
					pos = '0;
					ph  = PH_LEN_HI;
				end else begin
					pos++;
				end
				return;
			end
			PH_LEN_HI: begin
				left = {b, 8'h00};
				ph   = PH_LEN_LO;
				return;
			end
			PH_LEN_LO: begin
				left[7:0] = b;
				if (left < HDR_LEN) begin
					clear();
					emit(ST_SHORT_LEN);
				end else begin
					left = left - HDR_LEN;
					ph   = PH_TYPE;
				end
				return;
			end
			PH_TYPE: begin
				typ = b;
				pos = '0;
				ph  = (b == TYPE_UPDATE) ? PH_WL_HI : PH_BODY;
				if (left == 0)
					finish_msg();
				return;
			end
			default: ;
		endcase
		if (left == 0) begin
			clear();
			return;
		end
		left--;
		pos++;
		err = body_step(b);
		if (err != ST_OK) begin
			if (ferr == ST_OK)
				ferr = err;
			ph = PH_SKIP;
		end
		if (left == 0)
			finish_msg();
	endfunction

	task report(string msg);
		if (errors < 50)
			$display("[%0t] ERROR result %0d: %s", $time, checked, msg);
		errors++;
	endtask

	task field_cmp(string name, int unsigned got, int unsigned want);
		if (got != want)
			report($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
	endtask

	// compare one accepted result beat with the oldest prediction
	task check_beat(logic [OUT_TDATA_W-1:0] d);
		bmdc_result_t got, want;
		got = d[RESULT_W-1:0];
		if (summary_q.size() == 0) begin
			report($sformatf("result beat with nothing outstanding, tdata 0x%0h", d));
			return;
		end
		want = summary_q.pop_front();
		field_cmp("msg_type", got.msg_type, want.msg_type);
		field_cmp("payload_len", got.payload_len, want.payload_len);
		field_cmp("wd_pfx_cnt", got.wd_pfx_cnt, want.wd_pfx_cnt);
		field_cmp("nlri_pfx_cnt", got.nlri_pfx_cnt, want.nlri_pfx_cnt);
		field_cmp("path_attr_len", got.path_attr_len, want.path_attr_len);
		field_cmp("is_eor", got.is_eor, want.is_eor);
		field_cmp("peer_as", got.peer_as, want.peer_as);
		field_cmp("notify_code", got.notify_code, want.notify_code);
		field_cmp("notify_subcode", got.notify_subcode, want.notify_subcode);
		field_cmp("status", got.status, want.status);
		field_cmp("tdata padding", d[OUT_TDATA_W-1:RESULT_W], 0);
		st_seen[want.status]++;
		checked++;
	endtask
endclass

module tb_bgp_message_deframer_counter;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SRC = 0;
	localparam int SNK = 1;

	// ways to break an UPDATE body
	typedef enum int {
		FLAW_NONE,
		FLAW_WD_LONG,
		FLAW_NLRI_LONG,
		FLAW_WD_CUT,
		FLAW_NLRI_CUT,
		FLAW_WD_LEN,
		FLAW_ATTR_LEN
	} upd_flaw_e;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	msg_summary_board board;
	logic [7:0]  body_q[$];   // payload of the message being built
	logic [7:0]  pfx_q[$];    // prefix list being built
	int          beats_sent;
	int          msgs_sent;
	int          run_left[2];
	int          run_kind[2];
	int unsigned tick_cnt = 0;

	always #4 clk = ~clk;

	bgp_message_deframer_counter u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	// watchdog
	always @(posedge clk) begin
		tick_cnt <= tick_cnt + 1;
		if (tick_cnt == CYCLE_LIMIT) begin
			$display("[%0t] timeout after %0d cycles, %0d results outstanding",
				$time, tick_cnt, board.pending());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic logic [7:0] rnd_byte(int lo, int hi);
		return 8'($urandom_range(hi, lo));
	endfunction

	function automatic logic [7:0] bad_prefix_len();
		return ($urandom_range(0, 1) == 1) ? rnd_byte(128, 255) : rnd_byte(33, 127);
	endfunction

	// idle cycles before the next beat; runs of busy, light and heavy idling
	function automatic int draw_wait(input int side);
		if (run_left[side] == 0) begin
			run_left[side] = $urandom_range(4, 40);
			run_kind[side] = $urandom_range(0, 2);
		end
		run_left[side]--;
		case (run_kind[side])
			0:       return 0;
			1:       return $urandom_range(0, 2);
			default: return $urandom_range(0, 18);
		endcase
	endfunction

	// one input beat, held until accepted
	task automatic send_beat(input logic [7:0] b, input logic stream_end);
		int gap;
		gap = draw_wait(SRC);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= b;
		s_axis_tuser  <= stream_end;
		do @(posedge clk); while (!s_axis_tready);
		board.note_beat(b, stream_end);
		beats_sent++;
	endtask

	// append cnt bytes, lowest first
	task automatic load_body(input int cnt, input logic [63:0] bytes);
		for (int i = 0; i < cnt; i++)
			body_q.push_back(bytes[8*i +: 8]);
	endtask

	task automatic rand_body(input int cnt);
		body_q.delete();
		repeat (cnt) body_q.push_back(rnd_byte(0, 255));
	endtask

	// Header plus body_q. A declared payload longer than the body closes the
	// stream after the body; cut >= 0 closes it after that many bytes;
	// bad_at >= 0 spoils that marker byte and stops right after it.
	task automatic emit_message(input logic [15:0] len_field, input logic [7:0] mtype,
			input int cut, input int bad_at);
		logic [7:0] frame_q[$];
		int         n;
		bit         close;
		repeat (16) frame_q.push_back(MARKER_BYTE);
		frame_q.push_back(len_field[15:8]);
		frame_q.push_back(len_field[7:0]);
		frame_q.push_back(mtype);
		foreach (body_q[i]) frame_q.push_back(body_q[i]);
		close = 1'b0;
		if (len_field < HDR_LEN) begin
			n = 18;
		end else if (int'(len_field - HDR_LEN) > body_q.size()) begin
			n     = frame_q.size();
			close = 1'b1;
		end else begin
			n = 19 + int'(len_field - HDR_LEN);
		end
		if (bad_at >= 0) begin
			frame_q[bad_at] = rnd_byte(0, 8'hFE);
			n     = bad_at + 1;
			close = 1'b0;
		end
		if (cut >= 0 && cut < n) begin
			n     = cut;
			close = 1'b1;
		end
		for (int i = 0; i < n; i++)
			send_beat(frame_q[i], 1'b0);
		if (close)
			send_beat(rnd_byte(0, 255), 1'b1);
		msgs_sent++;
	endtask

	// prefix list into pfx_q, optionally one over-long prefix or a short tail
	task automatic add_prefixes(input int cnt, input bit long_one, input bit cut_last);
		int         bad_idx;
		int         need;
		logic [7:0] pl;
		pfx_q.delete();
		bad_idx = long_one ? int'($urandom_range(0, cnt - 1)) : -1;
		for (int i = 0; i < cnt; i++) begin
			pl = (i == bad_idx) ? bad_prefix_len() : rnd_byte(0, 32);
			pfx_q.push_back(pl);
			need = (pl > PREFIX_MAX) ? 0 : (int'(pl) + 7) / 8;
			repeat (need) pfx_q.push_back(rnd_byte(0, 255));
		end
		if (cut_last) begin
			pl = rnd_byte(1, 32);
			pfx_q.push_back(pl);
			repeat ($urandom_range(0, (int'(pl) + 7) / 8 - 1))
				pfx_q.push_back(rnd_byte(0, 255));
		end
	endtask

	// UPDATE payload into body_q
	task automatic build_update(input int n_wd, input int n_attr, input int n_nlri,
			input upd_flaw_e flaw);
		logic [7:0]  wd_q[$];
		logic [15:0] wd_len, at_len;
		int          total;
		if (flaw == FLAW_WD_LONG && n_wd == 0)
			n_wd = 1;
		if (flaw == FLAW_NLRI_LONG && n_nlri == 0)
			n_nlri = 1;
		add_prefixes(n_wd, flaw == FLAW_WD_LONG, flaw == FLAW_WD_CUT);
		wd_q = pfx_q;
		add_prefixes(n_nlri, flaw == FLAW_NLRI_LONG, flaw == FLAW_NLRI_CUT);
		total  = 4 + wd_q.size() + n_attr + pfx_q.size();
		wd_len = 16'(wd_q.size());
		at_len = 16'(n_attr);
		// section lengths that reach past the end of the payload
		if (flaw == FLAW_WD_LEN)
			wd_len = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
				16'(total - 1 + int'($urandom_range(0, 20)));
		if (flaw == FLAW_ATTR_LEN)
			at_len = ($urandom_range(0, 2) == 0) ? 16'hFFFF :
				16'(total - 3 - wd_q.size() + int'($urandom_range(0, 20)));
		body_q.delete();
		body_q.push_back(wd_len[15:8]);
		body_q.push_back(wd_len[7:0]);
		foreach (wd_q[i]) body_q.push_back(wd_q[i]);
		body_q.push_back(at_len[15:8]);
		body_q.push_back(at_len[7:0]);
		repeat (n_attr) body_q.push_back(rnd_byte(0, 255));
		foreach (pfx_q[i]) body_q.push_back(pfx_q[i]);
	endtask

	task automatic directed_cases();
		// stream end with no message open: nothing comes out
		send_beat(8'hA5, 1'b1);
		// keepalive
		body_q.delete();
		emit_message(16'd19, TYPE_KEEPALIVE, -1, -1);
		// OPEN with AS 65535, then one just long enough to hold the AS low byte
		body_q.delete();
		load_body(8, 64'h01_00_0A_B4_00_FF_FF_04);
		emit_message(16'd27, TYPE_OPEN, -1, -1);
		body_q.delete();
		load_body(3, 64'h12_04);
		emit_message(16'd22, TYPE_OPEN, -1, -1);
		// NOTIFICATION: all-ones code bytes, a normal one, an empty one
		body_q.delete();
		load_body(2, 64'hFF_FF);
		emit_message(16'd21, TYPE_NOTIFY, -1, -1);
		body_q.delete();
		load_body(3, 64'h00_02_06);
		emit_message(16'd22, TYPE_NOTIFY, -1, -1);
		body_q.delete();
		emit_message(16'd19, TYPE_NOTIFY, -1, -1);
		// end of RIB, then UPDATEs ending inside the length fields
		body_q.delete();
		load_body(4, 64'h0);
		emit_message(16'd23, TYPE_UPDATE, -1, -1);
		body_q.delete();
		emit_message(16'd19, TYPE_UPDATE, -1, -1);
		body_q.delete();
		load_body(3, 64'h0);
		emit_message(16'd22, TYPE_UPDATE, -1, -1);
		// clean UPDATE: 3 attribute bytes, a /0 and a /32
		body_q.delete();
		load_body(8, 64'h00_03_02_01_03_00_00_00);
		load_body(5, 64'h01_01_A8_C0_20);
		emit_message(16'd32, TYPE_UPDATE, -1, -1);
		// NLRI prefix length 255
		body_q.delete();
		load_body(5, 64'hFF_00_00_00_00);
		emit_message(16'd24, TYPE_UPDATE, -1, -1);
		// each broken UPDATE shape
		for (int f = int'(FLAW_WD_LONG); f <= int'(FLAW_ATTR_LEN); f++) begin
			build_update(2, 2, 2, upd_flaw_e'(f));
			emit_message(16'(19 + body_q.size()), TYPE_UPDATE, -1, -1);
		end
		// bad marker at the first and the last marker byte
		body_q.delete();
		emit_message(16'd19, TYPE_KEEPALIVE, -1, 0);
		emit_message(16'd19, TYPE_KEEPALIVE, -1, 15);
		// lengths below the header size
		emit_message(16'd0, TYPE_KEEPALIVE, -1, -1);
		emit_message(16'd18, TYPE_KEEPALIVE, -1, -1);
		// largest length, stream closed after a few bytes
		rand_body(3);
		emit_message(16'hFFFF, TYPE_OPEN, -1, -1);
		// stream closed inside the marker, after it, and after the type byte
		rand_body(11);
		emit_message(16'd30, TYPE_KEEPALIVE, 5, -1);
		emit_message(16'd30, TYPE_KEEPALIVE, 16, -1);
		emit_message(16'd30, TYPE_KEEPALIVE, 19, -1);
		// stream closed after an error was recorded
		build_update(3, 2, 2, FLAW_WD_LONG);
		emit_message(16'(19 + body_q.size()), TYPE_UPDATE, 19 + body_q.size() - 1, -1);
	endtask

	task automatic random_traffic(input int beat_goal, input int result_goal);
		int         beat_base, res_base, pick, cut;
		logic [7:0] mtype;
		beat_base = beats_sent;
		res_base  = board.produced;
		while (beats_sent - beat_base < beat_goal || board.produced - res_base < result_goal)
		begin
			pick  = $urandom_range(0, 99);
			mtype = TYPE_KEEPALIVE;
			body_q.delete();
			if (pick < 40) begin
				build_update($urandom_range(0, 4), $urandom_range(0, 8), $urandom_range(0, 5),
					(pick < 25) ? FLAW_NONE : upd_flaw_e'($urandom_range(1, 6)));
				mtype = TYPE_UPDATE;
			end else if (pick < 45) begin
				// short UPDATE payloads, often all zero so end of RIB shows up
				if ($urandom_range(0, 1) == 1)
					repeat ($urandom_range(0, 5)) body_q.push_back(8'h00);
				else
					rand_body($urandom_range(0, 5));
				mtype = TYPE_UPDATE;
			end else if (pick < 55) begin
				rand_body($urandom_range(0, 12));
				mtype = TYPE_OPEN;
			end else if (pick < 63) begin
				rand_body($urandom_range(0, 6));
				mtype = TYPE_NOTIFY;
			end else if (pick < 68) begin
				mtype = TYPE_KEEPALIVE;
			end else if (pick < 73) begin
				rand_body($urandom_range(0, 6));
				mtype = rnd_byte(0, 255);
			end
			cut = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 19 + body_q.size())) : -1;
			if (pick < 73)
				emit_message(16'(19 + body_q.size()), mtype, cut, -1);
			else if (pick < 79)
				emit_message(16'd19, mtype, -1, $urandom_range(0, 15));
			else if (pick < 84)
				emit_message(16'(rnd_byte(0, 18)), mtype, -1, -1);
			else if (pick < 89) begin
				rand_body($urandom_range(0, 8));
				emit_message(16'($urandom_range(60, 65535)), rnd_byte(0, 255), -1, -1);
			end else if (pick < 95) begin
				// line noise between messages
				repeat ($urandom_range(1, 4)) send_beat(rnd_byte(0, 8'hFE), 1'b0);
			end else begin
				send_beat(rnd_byte(0, 255), 1'b1);
			end
		end
	endtask

	// result sink with random back-pressure
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(SNK);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			board.check_beat(m_axis_tdata);
		end
	end

	// stimulus and end of run
	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		beats_sent    = 0;
		msgs_sent     = 0;
		run_left      = '{0, 0};
		run_kind      = '{0, 0};
		board         = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_cases();
		random_traffic(100, 4);
		// close whatever is still open
		send_beat(rnd_byte(0, 255), 1'b1);
		s_axis_tvalid <= 1'b0;

		while (board.pending() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d input beats in %0d framed messages, %0d results checked.",
			beats_sent, msgs_sent, board.checked);
		$display("Results by status ok..truncated: %0d %0d %0d %0d %0d %0d %0d %0d",
			board.st_seen[0], board.st_seen[1], board.st_seen[2], board.st_seen[3],
			board.st_seen[4], board.st_seen[5], board.st_seen[6], board.st_seen[7]);
		if (board.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### filelist.f
src/bmdc_pkg.sv
src/bmdc_in_reg.sv
src/bmdc_parser.sv
src/bmdc_out_reg.sv
src/bgp_message_deframer_counter.sv
sim/tb_bgp_message_deframer_counter.sv
